// File: rtl/core/lbc_pkg.sv
// Shared types, codes and constant tables for the layer blend combiner.
package lbc_pkg;

    localparam int MUL_W    = 34;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SUB_W    = 64;
    localparam int LOG_FRAC = 24;

    typedef enum logic [3:0] {
        BM_BLEND    = 4'd0,
        BM_ADD      = 4'd1,
        BM_SCREEN   = 4'd2,
        BM_SUBTRACT = 4'd3,
        BM_MULTIPLY = 4'd4,
        BM_DIVIDE   = 4'd5,
        BM_MAX      = 4'd6,
        BM_MIN      = 4'd7,
        BM_SQRT     = 4'd8,
        BM_POWER    = 4'd9,
        BM_DIFF     = 4'd10
    } t_method;

    typedef enum logic [1:0] {
        REG_BLEND_METHOD = 2'd0,
        REG_RANGE_MODE   = 2'd1,
        REG_USE_SHARED   = 2'd2,
        REG_SHARED_RATIO = 2'd3
    } t_reg_idx;

    typedef enum logic [13:0] {
        S_IDLE = 14'h0001,
        S_PREP = 14'h0002,
        S_METH = 14'h0004,
        S_DIV  = 14'h0008,
        S_DVF  = 14'h0010,
        S_SQRT = 14'h0020,
        S_SQF  = 14'h0040,
        S_NORM = 14'h0080,
        S_LOG  = 14'h0100,
        S_LGB  = 14'h0200,
        S_EXP  = 14'h0400,
        S_POWF = 14'h0800,
        S_LERP = 14'h1000,
        S_DONE = 14'h2000
    } t_state;

    typedef struct packed {
        logic signed [MUL_W-1:0] mul_a;
        logic signed [MUL_W-1:0] mul_b;
        logic [SUB_W-1:0]        sub_a;
        logic [SUB_W-1:0]        sub_b;
    } t_unit_req;

    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic [SUB_W-1:0]         diff;
        logic                     borrow;
    } t_unit_rsp;

    typedef logic [LOG_FRAC:0][31:0] t_root_tab;

    // Integer square root, rounded down.
    function automatic logic [63:0] f_isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Successive roots 2^(2^-i) in Q2.30, entry 0 being 2.0 in Q2.30.
    function automatic t_root_tab f_root_tab();
        t_root_tab   tab;
        logic [63:0] nxt;
        tab[0] = 32'h8000_0000;
        for (int i = 1; i <= LOG_FRAC; i++) begin
            nxt    = f_isqrt({2'b00, tab[i-1], 30'b0});
            tab[i] = nxt[31:0];
        end
        return tab;
    endfunction

    localparam t_root_tab ROOT_TAB = f_root_tab();

endpackage

// File: rtl/core/lbc_shared_unit.sv
// Shared multiplier and wide subtractor used by the arithmetic steps of the sequencer.
module lbc_shared_unit
    import lbc_pkg::*;
(
    input  t_unit_req i_req,
    output t_unit_rsp o_rsp
);

    logic [SUB_W:0] full_diff;

    assign full_diff     = {1'b0, i_req.sub_a} - {1'b0, i_req.sub_b};
    assign o_rsp.prod    = i_req.mul_a * i_req.mul_b;
    assign o_rsp.diff    = full_diff[SUB_W-1:0];
    assign o_rsp.borrow  = full_diff[SUB_W];

endmodule

// File: rtl/core/layer_blend_combiner.sv
// Top level of the layer blend combiner: sequencer, datapath registers and ports.
//
//  Channel   | Direction | Handshake          | Word contents
//  ----------+-----------+--------------------+--------------------------------------------
//  s_axis    | in        | tvalid/tready      | sample, scale_factor, layer_ratio; tuser
//            |           |                    | first_layer, tlast last_layer
//  m_axis    | out       | tvalid/tready      | blended_value
//  APB       | in        | psel/penable/pready| blend_method, range_mode, use_shared_ratio,
//            |           |                    | shared_ratio at byte addresses 0, 4, 8, 12
//
// A base word loads the accumulator in the idle state. A layer word runs a sequencer
// around one shared multiplier and one subtractor: prepare, method, then a loop if the
// method needs one (divide: one quotient bit per cycle, then a final step; square root:
// one root bit per cycle, then rounding; power: normalize, 24 log squarings, a product
// with the exponent, 24 exponent products on the multiplier, a final step), then the
// blend. A word that ends a pixel also passes the done state to load the output.
// The input is ready only while the sequencer is idle. A finished pixel sits in the
// output register; the next word is accepted while it waits, and the sequencer
// only stalls if a second result is ready before the first is taken.
// Reset is synchronous and active low; it clears the accumulator, the sequencer,
// the output valid and restores the register defaults. No clearing pass is needed.
module layer_blend_combiner
    import lbc_pkg::*;
#(
    parameter int VALUE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // sample [VALUE_BITS-1:0], scale_factor [+16], layer_ratio [+17], zero pad
    input  logic [((VALUE_BITS + 33 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // first_layer
    input  logic                  s_axis_tuser,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // blended_value [VALUE_BITS-1:0], zero pad
    output logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int W          = VALUE_BITS;
    localparam int OUT_DATA_W = ((VALUE_BITS + 7) / 8) * 8;
    localparam int DIV_W      = VALUE_BITS + FRAC_BITS;
    localparam int SQ_W       = 2 * VALUE_BITS - 1;
    localparam int CNT_W      = $clog2(DIV_W + 1);
    localparam int XW         = 72;

    localparam logic signed [XW-1:0] X_LSB    = 1;
    localparam logic signed [XW-1:0] VMAX_X   = (X_LSB <<< (VALUE_BITS - 1)) - X_LSB;
    localparam logic signed [XW-1:0] VMIN_X   = -VMAX_X - X_LSB;
    localparam logic signed [XW-1:0] VBIG_X   = VMAX_X + X_LSB;
    localparam logic signed [XW-1:0] ONE_X    = X_LSB <<< FRAC_BITS;
    localparam logic signed [XW-1:0] HI_X     = (ONE_X > VMAX_X) ? VMAX_X : ONE_X;
    localparam logic signed [XW-1:0] NONE_X   = -ONE_X;
    localparam logic signed [XW-1:0] LO_T_X   = (NONE_X < VMIN_X) ? VMIN_X : NONE_X;
    localparam logic signed [W-1:0]  HI_V     = HI_X[W-1:0];
    localparam logic signed [W-1:0]  LO_T_V   = LO_T_X[W-1:0];
    localparam logic signed [W-1:0]  ZERO_V   = '0;
    localparam logic [63:0]          VBIG_64  = VBIG_X[63:0];
    localparam logic [16:0]          RATIO_ONE = 17'h10000;

    function automatic logic signed [W-1:0] f_sat(input logic signed [XW-1:0] x);
        logic signed [W-1:0] res;
        if (x > VMAX_X) begin
            res = VMAX_X[W-1:0];
        end else if (x < VMIN_X) begin
            res = VMIN_X[W-1:0];
        end else begin
            res = x[W-1:0];
        end
        return res;
    endfunction

    // Shift right with rounding half up.
    function automatic logic signed [XW-1:0] f_rshift(input logic signed [XW-1:0] x,
                                                      input int s);
        return (x + (X_LSB <<< (s - 1))) >>> s;
    endfunction

    t_state              r_state, n_state;
    logic [3:0]          r_method;
    logic                r_range, r_use_shared;
    logic [16:0]         r_shared;
    logic signed [W-1:0] r_acc, n_acc, r_smp, n_smp, r_b, n_b, r_m, n_m;
    logic [15:0]         r_scale, n_scale;
    logic [16:0]         r_ratio, n_ratio;
    logic                r_last, n_last;
    logic [W-1:0]        r_rem, n_rem, r_ub, n_ub;
    logic [DIV_W-1:0]    r_dq, n_dq;
    logic                r_neg, n_neg;
    logic [SQ_W-1:0]     r_v, n_v, r_r, n_r, r_bit, n_bit;
    logic [31:0]         r_pm, n_pm, r_mant, n_mant;
    logic [4:0]          r_e, n_e;
    logic [LOG_FRAC-1:0] r_frac, n_frac;
    logic signed [63:0]  r_y, n_y;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_ovalid, n_ovalid;
    logic [W-1:0]        r_odata, n_odata;

    t_unit_req           req;
    t_unit_rsp           rsp;

    logic                in_acc;
    logic signed [W-1:0] in_sample;
    logic signed [XW-1:0] a_x, b_x, prod_x, mag_a_x, mag_b_x, tmp_x, q_x, v_x;
    logic signed [W-1:0] scr_a, scr_b, res_v, lo_v;
    logic [32:0]         sq;
    logic signed [6:0]   efs;
    logic signed [30:0]  lg;
    logic [4:0]          fb_idx, tab_idx;
    logic signed [63:0]  s_x;
    logic [5:0]          ns;
    logic [63:0]         v64;
    logic [16:0]         t_sel, t_cl;
    logic signed [W:0]   d_lerp;
    logic [SQ_W-1:0]     trial;

    lbc_shared_unit u_unit (
        .i_req (req),
        .o_rsp (rsp)
    );

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_sample     = s_axis_tdata[W-1:0];
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OUT_DATA_W'(r_odata);
    assign pready        = 1'b1;

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_BLEND_METHOD: prdata = {28'b0, r_method};
            REG_RANGE_MODE:   prdata = {31'b0, r_range};
            REG_USE_SHARED:   prdata = {31'b0, r_use_shared};
            REG_SHARED_RATIO: prdata = {15'b0, r_shared};
            default:          prdata = '0;
        endcase
    end

    // Operands shared by several steps.
    assign a_x     = XW'(r_acc);
    assign b_x     = XW'(r_b);
    assign prod_x  = XW'($signed(rsp.prod));
    assign mag_a_x = (a_x < 0) ? -a_x : a_x;
    assign mag_b_x = (b_x < 0) ? -b_x : b_x;
    assign scr_a   = f_sat(ONE_X - a_x);
    assign scr_b   = f_sat(ONE_X - b_x);
    assign efs     = $signed({2'b00, r_e}) - 7'(FRAC_BITS);
    assign lg      = $signed({efs, r_frac});
    assign fb_idx  = 5'(LOG_FRAC - 1) - r_cnt[4:0];
    assign tab_idx = r_cnt[4:0] + 5'd1;
    assign s_x     = (r_y >>> LOG_FRAC) + 64'(FRAC_BITS) - 64'sd30;
    assign ns      = 6'(-s_x);
    assign t_sel   = r_use_shared ? r_shared : r_ratio;
    assign t_cl    = (t_sel > RATIO_ONE) ? RATIO_ONE : t_sel;
    assign d_lerp  = $signed({r_m[W-1], r_m}) - $signed({r_acc[W-1], r_acc});
    assign trial   = r_r + r_bit;
    assign lo_v    = r_range ? LO_T_V : ZERO_V;

    always_comb begin
        n_state  = r_state;
        n_acc    = r_acc;
        n_smp    = r_smp;
        n_b      = r_b;
        n_m      = r_m;
        n_scale  = r_scale;
        n_ratio  = r_ratio;
        n_last   = r_last;
        n_rem    = r_rem;
        n_ub     = r_ub;
        n_dq     = r_dq;
        n_neg    = r_neg;
        n_v      = r_v;
        n_r      = r_r;
        n_bit    = r_bit;
        n_pm     = r_pm;
        n_mant   = r_mant;
        n_e      = r_e;
        n_frac   = r_frac;
        n_y      = r_y;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_odata  = r_odata;
        req      = '0;
        tmp_x    = '0;
        q_x      = '0;
        v_x      = '0;
        v64      = '0;
        sq       = '0;
        res_v    = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_smp   = in_sample;
                    n_scale = s_axis_tdata[W+15:W];
                    n_ratio = s_axis_tdata[W+32:W+16];
                    n_last  = s_axis_tlast;
                    if (s_axis_tuser) begin
                        // Base word loads the accumulator without clamping.
                        n_acc   = in_sample;
                        n_state = s_axis_tlast ? S_DONE : S_IDLE;
                    end else begin
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                req.mul_a = MUL_W'(r_smp);
                req.mul_b = MUL_W'({1'b0, r_scale});
                n_b       = r_range ? f_sat(f_rshift(prod_x, 8)) : r_smp;
                n_state   = S_METH;
            end
            S_METH: begin
                n_state = S_LERP;
                if (r_method == BM_SCREEN) begin
                    req.mul_a = MUL_W'(scr_a);
                    req.mul_b = MUL_W'(scr_b);
                end else begin
                    req.mul_a = MUL_W'(r_acc);
                    req.mul_b = MUL_W'(r_b);
                end
                case (r_method)
                    BM_ADD:      n_m = f_sat(a_x + b_x);
                    BM_SCREEN: begin
                        tmp_x = XW'(f_sat(f_rshift(prod_x, FRAC_BITS)));
                        n_m   = f_sat(ONE_X - tmp_x);
                    end
                    BM_SUBTRACT: n_m = f_sat(a_x - b_x);
                    BM_MULTIPLY: n_m = f_sat(f_rshift(prod_x, FRAC_BITS));
                    BM_DIVIDE: begin
                        if (r_b == ZERO_V) begin
                            n_m = r_acc;
                        end else begin
                            n_rem   = '0;
                            n_ub    = mag_b_x[W-1:0];
                            n_dq    = {mag_a_x[W-1:0], {FRAC_BITS{1'b0}}}
                                      + DIV_W'(mag_b_x[W-1:1]);
                            n_neg   = r_acc[W-1] ^ r_b[W-1];
                            n_cnt   = '0;
                            n_state = S_DIV;
                        end
                    end
                    BM_MAX:      n_m = (r_acc > r_b) ? r_acc : r_b;
                    BM_MIN:      n_m = (r_acc < r_b) ? r_acc : r_b;
                    BM_SQRT: begin
                        tmp_x   = (prod_x < 0) ? -prod_x : prod_x;
                        n_v     = tmp_x[SQ_W-1:0];
                        n_r     = '0;
                        n_bit   = SQ_W'(1) << (SQ_W - 1);
                        n_cnt   = '0;
                        n_state = S_SQRT;
                    end
                    BM_POWER: begin
                        if (r_acc == ZERO_V) begin
                            n_m = ZERO_V;
                        end else begin
                            n_pm    = 32'(mag_a_x[W-1:0]);
                            n_e     = 5'd31;
                            n_frac  = '0;
                            n_neg   = r_acc[W-1];
                            n_state = S_NORM;
                        end
                    end
                    BM_DIFF: begin
                        tmp_x = a_x - b_x;
                        n_m   = f_sat((tmp_x < 0) ? -tmp_x : tmp_x);
                    end
                    default:     n_m = r_b;
                endcase
            end
            S_DIV: begin
                // One restoring quotient bit per cycle.
                req.sub_a = SUB_W'({r_rem, r_dq[DIV_W-1]});
                req.sub_b = SUB_W'(r_ub);
                if (!rsp.borrow) begin
                    n_rem = rsp.diff[W-1:0];
                    n_dq  = {r_dq[DIV_W-2:0], 1'b1};
                end else begin
                    n_rem = {r_rem[W-2:0], r_dq[DIV_W-1]};
                    n_dq  = {r_dq[DIV_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    n_state = S_DVF;
                end
            end
            S_DVF: begin
                q_x     = XW'(r_dq);
                q_x     = (q_x > VBIG_X) ? VBIG_X : q_x;
                n_m     = f_sat(r_neg ? -q_x : q_x);
                n_state = S_LERP;
            end
            S_SQRT: begin
                req.sub_a = SUB_W'(r_v);
                req.sub_b = SUB_W'(trial);
                if (!rsp.borrow) begin
                    n_v = rsp.diff[SQ_W-1:0];
                    n_r = (r_r >> 1) + r_bit;
                end else begin
                    n_r = r_r >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(W - 1)) begin
                    n_state = S_SQF;
                end
            end
            S_SQF: begin
                // The leftover is the root's distance to the square: round to nearest.
                q_x     = XW'(r_r) + ((r_v > r_r) ? X_LSB : '0);
                n_m     = f_sat(q_x);
                n_state = S_LERP;
            end
            S_NORM: begin
                if (r_pm[31]) begin
                    n_cnt   = '0;
                    n_state = S_LOG;
                end else begin
                    n_pm = {r_pm[30:0], 1'b0};
                    n_e  = r_e - 5'd1;
                end
            end
            S_LOG: begin
                // One log2 fraction bit per squaring of the mantissa.
                req.mul_a = MUL_W'({1'b0, r_pm});
                req.mul_b = MUL_W'({1'b0, r_pm});
                sq        = rsp.prod[63:31];
                if (sq[32]) begin
                    n_pm   = sq[32:1];
                    n_frac = {r_frac[LOG_FRAC-2:0], 1'b1};
                end else begin
                    n_pm   = sq[31:0];
                    n_frac = {r_frac[LOG_FRAC-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(LOG_FRAC - 1)) begin
                    n_state = S_LGB;
                end
            end
            S_LGB: begin
                req.mul_a = MUL_W'(lg);
                req.mul_b = MUL_W'(r_b);
                tmp_x     = f_rshift(prod_x, FRAC_BITS);
                n_y       = tmp_x[63:0];
                n_mant    = 32'h4000_0000;
                n_cnt     = '0;
                n_state   = S_EXP;
            end
            S_EXP: begin
                req.mul_a = MUL_W'({1'b0, r_mant});
                req.mul_b = MUL_W'({1'b0, ROOT_TAB[tab_idx]});
                if (r_y[fb_idx]) begin
                    tmp_x  = (prod_x + (X_LSB <<< 29)) >>> 30;
                    n_mant = tmp_x[31:0];
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(LOG_FRAC - 1)) begin
                    n_state = S_POWF;
                end
            end
            S_POWF: begin
                if (s_x >= 64'sd32) begin
                    v64 = VBIG_64;
                end else if (s_x >= 64'sd0) begin
                    v64 = {32'b0, r_mant} << s_x[4:0];
                end else if (s_x < -64'sd62) begin
                    v64 = '0;
                end else begin
                    v64 = ({32'b0, r_mant} + (64'd1 << (ns - 6'd1))) >> ns;
                end
                if (v64 > VBIG_64) begin
                    v64 = VBIG_64;
                end
                v_x     = XW'(v64);
                n_m     = f_sat(r_neg ? -v_x : v_x);
                n_state = S_LERP;
            end
            S_LERP: begin
                req.mul_a = MUL_W'(d_lerp);
                req.mul_b = MUL_W'({1'b0, t_cl});
                res_v     = f_sat(a_x + f_rshift(prod_x, 16));
                if (res_v > HI_V) begin
                    res_v = HI_V;
                end
                if (res_v < lo_v) begin
                    res_v = lo_v;
                end
                n_acc   = res_v;
                n_state = r_last ? S_DONE : S_IDLE;
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_acc;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_acc        <= '0;
            r_ovalid     <= 1'b0;
            r_method     <= BM_BLEND;
            r_range      <= 1'b0;
            r_use_shared <= 1'b1;
            r_shared     <= 17'd32768;
        end else begin
            r_state  <= n_state;
            r_acc    <= n_acc;
            r_ovalid <= n_ovalid;
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_BLEND_METHOD: r_method     <= pwdata[3:0];
                    REG_RANGE_MODE:   r_range      <= pwdata[0];
                    REG_USE_SHARED:   r_use_shared <= pwdata[0];
                    REG_SHARED_RATIO: r_shared     <= pwdata[16:0];
                    default:          r_method     <= r_method;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_smp   <= n_smp;
        r_b     <= n_b;
        r_m     <= n_m;
        r_scale <= n_scale;
        r_ratio <= n_ratio;
        r_last  <= n_last;
        r_rem   <= n_rem;
        r_ub    <= n_ub;
        r_dq    <= n_dq;
        r_neg   <= n_neg;
        r_v     <= n_v;
        r_r     <= n_r;
        r_bit   <= n_bit;
        r_pm    <= n_pm;
        r_mant  <= n_mant;
        r_e     <= n_e;
        r_frac  <= n_frac;
        r_y     <= n_y;
        r_cnt   <= n_cnt;
        r_odata <= n_odata;
    end

    // A folded layer always leaves the accumulator inside the clamp window.
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LERP) |=> (r_acc <= HI_V) && (r_acc >= lo_v))
        else $error("accumulator outside clamp window after a layer");

    // A base word loads the accumulator exactly.
    a_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser) |=> (r_acc == $past(in_sample)))
        else $error("base word did not load the accumulator");

    // The divider remainder stays below the divisor on every step.
    a_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_ub))
        else $error("divider remainder not below divisor");

    // Leaving the done state publishes the accumulator on the output.
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (!r_ovalid || m_axis_tready))
        |=> (r_ovalid && (r_odata == $past(r_acc))))
        else $error("pixel result not published");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the layer blend combiner: stream driver, monitor, predictor.
`timescale 1ns / 1ps

module tb;
    import lbc_pkg::*;

    localparam longint VMAX  = 32767;
    localparam longint VMIN  = -32768;
    localparam longint ONE   = 16384;
    localparam int     LIMIT = 1000000;
    localparam int     SETTLE = 200;

    typedef struct {
        logic signed [15:0] sample;
        logic [15:0]        scale;
        logic [16:0]        ratio;
        logic               first;
        logic               last;
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // sample [15:0], scale_factor [31:16], layer_ratio [48:32], zero pad [55:49]
    logic [55:0] s_axis_tdata = '0;
    // first_layer
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // blended_value [15:0]
    logic [15:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    layer_blend_combiner dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Shadow copy of the configuration and the accumulator.
    logic [3:0]  cfg_method = BM_BLEND;
    logic        cfg_terrain = 1'b0;
    logic        cfg_shared = 1'b1;
    logic [16:0] cfg_ratio = 17'd32768;
    longint      acc_q = 0;

    t_word       pend_words[$];
    logic [15:0] pixel_results[$];
    t_word       cur_word;
    int          errors = 0;
    int          cycles = 0;

    // ---------------- fixed-point arithmetic ----------------
    function automatic longint sat16(longint x);
        if (x > VMAX) return VMAX;
        if (x < VMIN) return VMIN;
        return x;
    endfunction

    function automatic longint floor_shr(longint y, int s);
        logic [63:0] u;
        if (y >= 0) return longint'(64'(y) >> s);
        u = -y;
        return -longint'((u + ((64'd1 << s) - 64'd1)) >> s);
    endfunction

    function automatic longint round_shr(longint x, int s);
        if (s == 0) return x;
        return floor_shr(x + (64'sd1 <<< (s - 1)), s);
    endfunction

    function automatic longint q_mul(longint a, longint b);
        return sat16(round_shr(a * b, 14));
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v_in);
        logic [63:0] v, r, bt;
        v = v_in;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= r + bt) begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    function automatic longint q_div(longint a, longint b);
        longint      num;
        logic        neg;
        logic [63:0] un, ub, q;
        num = a * ONE;
        neg = (num < 0) != (b < 0);
        un = (num < 0) ? -num : num;
        ub = (b < 0) ? -b : b;
        q = (un + ub / 2) / ub;
        if (q > 64'(VMAX + 1)) q = VMAX + 1;
        return sat16(neg ? -longint'(q) : longint'(q));
    endfunction

    function automatic longint q_sqrt_prod(longint a, longint b);
        longint      p;
        logic [63:0] up, r;
        p = a * b;
        up = (p < 0) ? -p : p;
        r = int_sqrt(up);
        if (up - r * r > r) r = r + 1;
        return sat16(longint'(r));
    endfunction

    function automatic longint q_pow(longint a, longint b);
        logic [63:0] x, m, frac, mant;
        logic [63:0] c [0:24];
        int          e;
        longint      lg, y, k, f, s, v;
        if (a == 0) return 0;
        x = (a < 0) ? -a : a;
        e = 31;
        while (x[e] == 1'b0) e--;
        m = x << (31 - e);
        frac = 0;
        // Log2 fraction bits by repeated squaring of the normalized mantissa.
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        lg = longint'(e - 14) * (64'sd1 <<< 24) + longint'(frac);
        y = round_shr(lg * b, 14);
        k = floor_shr(y, 24);
        f = y - k * (64'sd1 <<< 24);
        c[0] = 64'd1 << 31;
        for (int i = 1; i <= 24; i++) c[i] = int_sqrt(c[i-1] << 30);
        mant = 64'd1 << 30;
        for (int i = 1; i <= 24; i++)
            if (f[24-i]) mant = (mant * c[i] + (64'd1 << 29)) >> 30;
        s = k + 14 - 30;
        if (s >= 32) v = VMAX + 1;
        else if (s >= 0) v = longint'(mant << s);
        else if (-s > 62) v = 0;
        else v = round_shr(longint'(mant), int'(-s));
        if (v > VMAX + 1) v = VMAX + 1;
        return sat16((a < 0) ? -v : v);
    endfunction

    function automatic longint combine(longint a, longint b, logic [3:0] meth);
        longint d;
        case (meth)
            BM_ADD:      return sat16(a + b);
            BM_SCREEN:   return sat16(ONE - q_mul(sat16(ONE - a), sat16(ONE - b)));
            BM_SUBTRACT: return sat16(a - b);
            BM_MULTIPLY: return q_mul(a, b);
            BM_DIVIDE:   return (b == 0) ? a : q_div(a, b);
            BM_MAX:      return (a > b) ? a : b;
            BM_MIN:      return (a < b) ? a : b;
            BM_SQRT:     return q_sqrt_prod(a, b);
            BM_POWER:    return q_pow(a, b);
            BM_DIFF: begin
                d = a - b;
                return sat16((d < 0) ? -d : d);
            end
            default:     return b;
        endcase
    endfunction

    // Folds one accepted word into the shadow accumulator and queues the pixel on a last word.
    task automatic fold_word(t_word w);
        longint b, mv, r, t, lo;
        if (w.first) begin
            acc_q = longint'(w.sample);
        end else begin
            b = cfg_terrain ? sat16(round_shr(longint'(w.sample) * longint'(w.scale), 8))
                            : longint'(w.sample);
            t = cfg_shared ? longint'(cfg_ratio) : longint'(w.ratio);
            if (t > 65536) t = 65536;
            mv = combine(acc_q, b, cfg_method);
            r = sat16(acc_q + round_shr((mv - acc_q) * t, 16));
            lo = cfg_terrain ? -ONE : 0;
            if (r > ONE) r = ONE;
            if (r < lo) r = lo;
            acc_q = r;
        end
        if (w.last) pixel_results.push_back(acc_q[15:0]);
    endtask

    // ---------------- stream driver ----------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) fold_word(cur_word);
            if (s_axis_tvalid && !s_axis_tready) begin
                // Word still pending; hold everything.
            end else if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pend_words.size() != 0) begin
                cur_word = pend_words.pop_front();
                s_axis_tdata <= {7'b0, cur_word.ratio, cur_word.scale, cur_word.sample};
                s_axis_tuser <= cur_word.first;
                s_axis_tlast <= cur_word.last;
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- result monitor ----------------
    int run_left = 0;
    int stall_left = 0;
    logic [15:0] want;

    always @(posedge i_clk) begin
        if (run_left > 0) begin
            run_left--;
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            run_left = $urandom_range(0, 20);
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            m_axis_tready <= 1'b1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pixel_results.size() == 0) begin
                $error("blended_value: no result expected, got %h", m_axis_tdata[15:0]);
                errors++;
            end else begin
                want = pixel_results.pop_front();
                if (m_axis_tdata[15:0] !== want) begin
                    $error("blended_value: expected %h, actual %h", want, m_axis_tdata[15:0]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic reg_write(t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_BLEND_METHOD: cfg_method = val[3:0];
            REG_RANGE_MODE:   cfg_terrain = val[0];
            REG_USE_SHARED:   cfg_shared = val[0];
            default:          cfg_ratio = val[16:0];
        endcase
    endtask

    task automatic set_config(logic [3:0] meth, logic terr, logic shr, logic [16:0] ratio);
        reg_write(REG_BLEND_METHOD, 32'(meth));
        reg_write(REG_RANGE_MODE, 32'(terr));
        reg_write(REG_USE_SHARED, 32'(shr));
        reg_write(REG_SHARED_RATIO, 32'(ratio));
    endtask

    // Lets every queued word and its pixel drain, then settles the sequencer.
    task automatic drain();
        while (pend_words.size() != 0 || s_axis_tvalid || pixel_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic push(logic [15:0] smp, logic [15:0] scl, logic [16:0] rat,
                        logic fst, logic lst);
        t_word w;
        w.sample = smp;
        w.scale = scl;
        w.ratio = rat;
        w.first = fst;
        w.last = lst;
        pend_words.push_back(w);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0, 1:    return 16'($urandom());
            2:       return 16'h0000;
            3:       return 16'(ONE);
            4:       return 16'(-ONE);
            5:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic logic [15:0] pick_scale();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom());
            1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(128, 512));
        endcase
    endfunction

    function automatic logic [16:0] pick_ratio();
        case ($urandom_range(0, 4))
            0:       return 17'($urandom());
            1:       return 17'd65536;
            2:       return 17'd0;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic make_pixels(int n);
        int cnt, layers;
        cnt = 0;
        while (cnt < n) begin
            if ($urandom_range(0, 99) < 85) begin
                layers = $urandom_range(0, 9);
                push(pick_sample(), pick_scale(), pick_ratio(), 1'b1, layers == 0);
                for (int j = 0; j < layers; j++)
                    push(pick_sample(), pick_scale(), pick_ratio(), 1'b0, j == layers - 1);
                cnt += layers + 1;
            end else begin
                // Stray word with arbitrary markers.
                push(pick_sample(), pick_scale(), pick_ratio(), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
                cnt++;
            end
        end
    endtask

    logic [16:0] ph_ratio;

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: a layer without a base folds into the cleared accumulator.
        push(16'h7FFF, 16'h0100, 17'd0, 1'b0, 1'b1);
        push(16'h8000, 16'hFFFF, 17'h1FFFF, 1'b1, 1'b1);
        drain();

        // Terrain divide with per-word ratios: zero divisor, extremes, over-one ratio.
        set_config(BM_DIVIDE, 1'b1, 1'b0, 17'd0);
        push(16'(ONE / 2), 16'h0100, 17'd0, 1'b1, 1'b0);
        push(16'h0000, 16'h0100, 17'd65536, 1'b0, 1'b1);
        push(16'h7FFF, 16'h0000, 17'd65536, 1'b1, 1'b0);
        push(16'h8000, 16'hFFFF, 17'h1FFFF, 1'b0, 1'b1);
        push(16'h1000, 16'h0100, 17'd65536, 1'b1, 1'b0);
        push(16'h0001, 16'h0100, 17'd40000, 1'b0, 1'b1);
        drain();

        // Power with negative base and shared ratio of one.
        set_config(BM_POWER, 1'b1, 1'b1, 17'd65536);
        push(16'(-ONE / 2), 16'h0100, 17'd0, 1'b1, 1'b0);
        push(16'(ONE * 3 / 2), 16'h0100, 17'd0, 1'b0, 1'b1);
        push(16'h0000, 16'h0100, 17'd0, 1'b1, 1'b0);
        push(16'h8000, 16'hFFFF, 17'd0, 1'b0, 1'b1);
        push(16'h0001, 16'h0100, 17'd0, 1'b1, 1'b0);
        push(16'h7FFF, 16'h0100, 17'd0, 1'b0, 1'b1);
        drain();

        // Square root and an unknown method code in scalar mode.
        set_config(BM_SQRT, 1'b0, 1'b1, 17'h1FFFF);
        push(16'h8000, 16'h0100, 17'd0, 1'b1, 1'b0);
        push(16'h8000, 16'h0100, 17'd0, 1'b0, 1'b1);
        drain();
        set_config(4'd15, 1'b0, 1'b1, 17'd0);
        push(16'(ONE), 16'h0100, 17'd0, 1'b1, 1'b0);
        push(16'h0000, 16'h0100, 17'd0, 1'b0, 1'b1);
        drain();

        // Random phases sweep every method code with random range, ratio and shared settings.
        for (int p = 0; p < 24; p++) begin
            case ($urandom_range(0, 4))
                0:       ph_ratio = 17'd0;
                1:       ph_ratio = 17'd65536;
                2:       ph_ratio = 17'h1FFFF;
                default: ph_ratio = 17'($urandom());
            endcase
            set_config(4'(p % 16), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       ph_ratio);
            make_pixels(73);
            drain();
        end

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
